// File: sv/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg: shared types and constants of the frame parser
// Payload structs, result codes, frame layout and controller command types.
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam int WINDOW_BYTES_DEF = 64;
	localparam int MAX_PAYLOAD_DEF  = 32;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam int          HDR_BYTES   = 8;
	localparam int          FRAME_EXTRA = 10;

	localparam logic [2:0] RC_NONE    = 3'd0;
	localparam logic [2:0] RC_FRAME   = 3'd1;
	localparam logic [2:0] RC_TIMEOUT = 3'd2;
	localparam logic [2:0] RC_BADLEN  = 3'd3;
	localparam logic [2:0] RC_BADCRC  = 3'd4;
	localparam logic [2:0] RC_PUSHED  = 3'd5;
	localparam logic [2:0] RC_FULL    = 3'd6;

	localparam logic [1:0] REG_MARK0   = 2'd0;
	localparam logic [1:0] REG_MARK1   = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;
	localparam logic [1:0] REG_LIMIT   = 2'd3;

	typedef struct packed {
		logic        operation;
		logic [7:0]  rx_byte;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  result_code;
		logic [7:0]  version;
		logic [7:0]  frame_type;
		logic [7:0]  frame_flags;
		logic [15:0] sequence_res;
		logic [5:0]  pay_len;
		logic [7:0]  payload_byte;
		logic        last;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load;        // capture request fields
		logic       push;        // write byte at tail
		logic       rd;          // read window at offset
		logic [6:0] rd_ofs;      // offset from head (up to 127 unused high)
		logic       drop_one;    // advance head by one
		logic       drop_frame;  // advance head by frame length
		logic       crc_init;
		logic       crc_step;    // fold registered read byte into crc
		logic       cap_len;
		logic       cap_ver;
		logic       cap_type;
		logic       cap_flags;
		logic       cap_seq_lo;
		logic       cap_seq_hi;
		logic       cap_crc_lo;
		logic       cap_crc_hi;
		logic       cap_pay;     // take registered read byte as payload byte
	} dp_cmd_t;

	// datapath status to controller
	typedef struct packed {
		logic [7:0]  rd_data;
		logic [10:0] count;
		logic        stale;
		logic        len_bad;
		logic        crc_ok;
		logic [5:0]  len;
		logic [7:0]  mark0;
		logic [7:0]  mark1;
	} dp_stat_t;

endpackage

// File: sv/sfp_datapath.sv
// ----------------------------------------------------------------------------
// sfp_datapath: ring window, crc unit and captured header fields
// Executes one command set per cycle from the controller.
// ----------------------------------------------------------------------------
module sfp_datapath
	import sfp_pkg::*;
#(
	parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
	parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] now_ms,
	input  logic [7:0]  cfg_mark0,
	input  logic [7:0]  cfg_mark1,
	input  logic [15:0] cfg_timeout,
	input  logic [5:0]  cfg_limit,
	output dp_stat_t    stat,
	output logic [7:0]  version,
	output logic [7:0]  frame_type,
	output logic [7:0]  frame_flags,
	output logic [15:0] sequence_res,
	output logic [7:0]  payload_byte
);
	localparam int AW = $clog2(WINDOW_BYTES);
	localparam int CW = $clog2(WINDOW_BYTES + 1);

	logic [7:0]    mem [WINDOW_BYTES];
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [31:0]   last_time_q;
	logic [7:0]    byte_q;
	logic [31:0]   now_q;
	logic [7:0]    rd_q;
	logic [15:0]   crc_q;
	logic [5:0]    len_q;
	logic [7:0]    crc_lo_q;
	logic [7:0]    crc_hi_q;
	logic [7:0]    ver_q, type_q, flags_q, seq_lo_q, seq_hi_q;
	logic [7:0]    pay_q;
	logic [15:0]   crc_nxt;
	logic [5:0]    limit_eff;
	logic [AW-1:0] tail, rd_addr;
	logic [CW-1:0] flen;

	// ring addressing, wraps for power-of-two and other depths
	function automatic logic [AW-1:0] ring_add(logic [AW-1:0] a, logic [CW:0] b);
		logic [CW+1:0] s;
		s = {{(CW+2-AW){1'b0}}, a} + {1'b0, b};
		if (s >= (CW+2)'(WINDOW_BYTES)) s = s - (CW+2)'(WINDOW_BYTES);
		return s[AW-1:0];
	endfunction

	assign tail    = ring_add(head_q, {1'b0, count_q});
	assign rd_addr = ring_add(head_q, (CW+1)'(cmd.rd_ofs));
	assign flen    = CW'(FRAME_EXTRA) + CW'(len_q);

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= rx_byte;
			now_q  <= now_ms;
		end
	end

	// window memory
	always_ff @(posedge clk) begin
		if (cmd.push) mem[tail] <= byte_q;
		if (cmd.rd) rd_q <= mem[rd_addr];
	end

	// crc, one byte per step
	always_comb begin
		crc_nxt = crc_q ^ {rd_q, 8'h00};
		for (int b = 0; b < 8; b++)
			crc_nxt = crc_nxt[15] ? ((crc_nxt << 1) ^ CRC_POLY) : (crc_nxt << 1);
	end

	// head, count and timestamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			last_time_q <= '0;
		end else if (cmd.push) begin
			count_q     <= count_q + CW'(1);
			last_time_q <= now_q;
		end else if (cmd.drop_one) begin
			if (count_q <= CW'(1)) begin
				head_q <= '0; count_q <= '0;
			end else begin
				head_q <= ring_add(head_q, (CW+1)'(1)); count_q <= count_q - CW'(1);
			end
		end else if (cmd.drop_frame) begin
			if (flen >= count_q) begin
				head_q <= '0; count_q <= '0;
			end else begin
				head_q <= ring_add(head_q, {1'b0, flen}); count_q <= count_q - flen;
			end
		end
	end

	// captured fields
	always_ff @(posedge clk) begin
		if (cmd.crc_init) crc_q <= CRC_INIT;
		else if (cmd.crc_step) crc_q <= crc_nxt;
		if (cmd.cap_len)    len_q    <= rd_q[5:0];
		if (cmd.cap_ver)    ver_q    <= rd_q;
		if (cmd.cap_type)   type_q   <= rd_q;
		if (cmd.cap_flags)  flags_q  <= rd_q;
		if (cmd.cap_seq_lo) seq_lo_q <= rd_q;
		if (cmd.cap_seq_hi) seq_hi_q <= rd_q;
		if (cmd.cap_crc_lo) crc_lo_q <= rd_q;
		if (cmd.cap_crc_hi) crc_hi_q <= rd_q;
		if (cmd.load) pay_q <= '0;
		else if (cmd.cap_pay) pay_q <= rd_q;
	end

	assign limit_eff = ({1'b0, cfg_limit} > 7'(MAX_PAYLOAD)) ? 6'(MAX_PAYLOAD) : cfg_limit;

	// status
	always_comb begin
		stat         = '0;
		stat.rd_data = rd_q;
		stat.count   = 11'(count_q);
		stat.stale   = (now_q - last_time_q) >= {16'h0, cfg_timeout};
		stat.len_bad = ({1'b0, rd_q} > {3'b0, limit_eff});
		stat.crc_ok  = ({crc_hi_q, crc_lo_q} == crc_q);
		stat.len     = len_q;
		stat.mark0   = cfg_mark0;
		stat.mark1   = cfg_mark1;
	end

	assign version      = ver_q;
	assign frame_type   = type_q;
	assign frame_flags  = flags_q;
	assign sequence_res = {seq_hi_q, seq_lo_q};
	assign payload_byte = pay_q;

endmodule

// File: sv/sfp_ctrl.sv
// ----------------------------------------------------------------------------
// sfp_ctrl: parser sequencer
// Walks the window one read per step and issues datapath commands and results.
// ----------------------------------------------------------------------------
module sfp_ctrl
	import sfp_pkg::*;
#(
	parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       in_op,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] out_code,
	output logic       out_frame,
	output logic       out_last,
	output dp_cmd_t    cmd,
	input  dp_stat_t   stat
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD0   = 4'd1;
	localparam logic [3:0] S_CK0   = 4'd2;
	localparam logic [3:0] S_CK1   = 4'd3;
	localparam logic [3:0] S_LEN   = 4'd4;
	localparam logic [3:0] S_HRD   = 4'd5;
	localparam logic [3:0] S_CRC   = 4'd6;
	localparam logic [3:0] S_CRCK  = 4'd7;
	localparam logic [3:0] S_PRD   = 4'd8;
	localparam logic [3:0] S_PCAP  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;
	localparam logic [3:0] S_PUSH  = 4'd11;

	logic [3:0] state_q;
	logic [6:0] ofs_q;     // running offset
	logic [6:0] k_q;       // payload index
	logic [2:0] code_q;
	logic       frame_q;
	logic       rlast_q;
	logic [6:0] crc_end;
	logic [6:0] crc_last;
	logic [6:0] flen;
	logic       take;

	assign take     = (state_q == S_IDLE) && in_valid;
	assign crc_end  = 7'(HDR_BYTES) + {1'b0, stat.len};
	assign crc_last = crc_end + 7'd1;
	assign flen     = 7'(FRAME_EXTRA) + {1'b0, stat.len};

	// command decode
	always_comb begin
		cmd        = '0;
		cmd.load   = take;
		cmd.rd_ofs = ofs_q;
		case (state_q)
			S_PUSH: cmd.push = 1'b1;
			S_RD0:  cmd.rd = 1'b1;
			S_CK0: begin
				if (stat.rd_data != stat.mark0) cmd.drop_one = 1'b1;
				else if (stat.count >= 11'd2) begin
					cmd.rd = 1'b1; cmd.rd_ofs = 7'd1;
				end else if (stat.stale) cmd.drop_one = 1'b1;
			end
			S_CK1: begin
				if (stat.rd_data != stat.mark1) cmd.drop_one = 1'b1;
				else if (stat.count >= 11'(HDR_BYTES)) begin
					cmd.rd = 1'b1; cmd.rd_ofs = 7'd7;
				end else if (stat.stale) cmd.drop_one = 1'b1;
			end
			S_LEN: begin
				cmd.cap_len = 1'b1;
				if (stat.len_bad) cmd.drop_one = 1'b1;
			end
			S_HRD: begin
				if (stat.count < 11'(flen)) begin
					if (stat.stale) cmd.drop_one = 1'b1;
				end else begin
					cmd.rd = 1'b1; cmd.rd_ofs = 7'd2; cmd.crc_init = 1'b1;
				end
			end
			S_CRC: begin
				// read of offset ofs_q lands while ofs_q+1 is issued
				cmd.rd         = (ofs_q <= crc_last);
				cmd.crc_step   = ofs_q inside {[7'd3:crc_end]};
				cmd.cap_ver    = (ofs_q == 7'd3);
				cmd.cap_type   = (ofs_q == 7'd4);
				cmd.cap_flags  = (ofs_q == 7'd5);
				cmd.cap_seq_lo = (ofs_q == 7'd6);
				cmd.cap_seq_hi = (ofs_q == 7'd7);
				cmd.cap_crc_lo = (ofs_q == crc_last);
				cmd.cap_crc_hi = (ofs_q == crc_last + 7'd1);
			end
			S_CRCK: if (!stat.crc_ok) cmd.drop_one = 1'b1;
			S_PRD:  cmd.rd = 1'b1;
			S_PCAP: cmd.cap_pay = 1'b1;
			S_OUT: if (!out_stall && rlast_q && frame_q) cmd.drop_frame = 1'b1;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ofs_q   <= '0;
			k_q     <= '0;
			code_q  <= RC_NONE;
			frame_q <= 1'b0;
			rlast_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					frame_q <= 1'b0;
					rlast_q <= 1'b1;
					ofs_q   <= '0;
					if (!in_op) begin
						if (stat.count >= 11'(WINDOW_BYTES)) begin
							code_q <= RC_FULL; state_q <= S_OUT;
						end else begin
							code_q <= RC_PUSHED; state_q <= S_PUSH;
						end
					end else if (stat.count == 11'd0) begin
						code_q <= RC_NONE; state_q <= S_OUT;
					end else state_q <= S_RD0;
				end
				S_PUSH: state_q <= S_OUT;
				S_RD0: state_q <= S_CK0;
				S_CK0: begin
					if (stat.rd_data != stat.mark0) begin
						state_q <= (stat.count <= 11'd1) ? S_OUT : S_RD0;
						code_q  <= RC_NONE;
					end else if (stat.count >= 11'd2) state_q <= S_CK1;
					else begin
						code_q <= stat.stale ? RC_TIMEOUT : RC_NONE; state_q <= S_OUT;
					end
				end
				S_CK1: begin
					if (stat.rd_data != stat.mark1) begin
						state_q <= S_RD0; // count stays >= 1 after dropping
					end else if (stat.count >= 11'(HDR_BYTES)) state_q <= S_LEN;
					else begin
						code_q <= stat.stale ? RC_TIMEOUT : RC_NONE; state_q <= S_OUT;
					end
				end
				S_LEN: begin
					if (stat.len_bad) begin
						code_q <= RC_BADLEN; state_q <= S_OUT;
					end else state_q <= S_HRD;
				end
				S_HRD: begin
					if (stat.count < 11'(flen)) begin
						code_q <= stat.stale ? RC_TIMEOUT : RC_NONE; state_q <= S_OUT;
					end else begin
						ofs_q <= 7'd3; state_q <= S_CRC;
					end
				end
				S_CRC: begin
					ofs_q <= ofs_q + 7'd1;
					if (ofs_q == crc_last + 7'd1) state_q <= S_CRCK;
				end
				S_CRCK: begin
					if (!stat.crc_ok) begin
						code_q <= RC_BADCRC; state_q <= S_OUT;
					end else begin
						code_q <= RC_FRAME; frame_q <= 1'b1; k_q <= '0;
						if (stat.len == 6'd0) begin
							rlast_q <= 1'b1; state_q <= S_OUT;
						end else begin
							ofs_q <= 7'(HDR_BYTES); state_q <= S_PRD;
						end
					end
				end
				S_PRD: state_q <= S_PCAP;
				S_PCAP: begin
					rlast_q <= (k_q + 7'd1 == {1'b0, stat.len});
					state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) begin
					if (rlast_q) state_q <= S_IDLE;
					else begin
						k_q <= k_q + 7'd1; ofs_q <= ofs_q + 7'd1; state_q <= S_PRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// handshake and result status
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_code  = code_q;
	assign out_frame = frame_q;
	assign out_last  = rlast_q;

endmodule

// File: sv/sof_frame_parser_crc16_top.sv
// ----------------------------------------------------------------------------
// sof_frame_parser_crc16_top: length-prefixed frame parser with crc-16 check
// Request channel in_*, result channel out_*, register writes on cfg_*.
// One request is handled at a time; in_stall stays high from the accepting
// edge until the last result of that request has been taken.
// A push goes through accept, window write and result and gives one result;
// a push into a full window skips the write. A poll walks the window with one
// registered memory read per step: a byte that fails the first start mark is
// read, checked and dropped, a head byte whose successor fails the second mark
// is dropped once that successor is read and checked, and a complete frame is
// read through to its crc verdict; each payload result is then read, captured
// and output (an empty payload goes straight to its result). The registered window read sets this order.
// Reset empties the window and loads the register defaults. While results are
// stalled the block holds its state and takes no new request.
// ----------------------------------------------------------------------------
module sof_frame_parser_crc16_top
	import sfp_pkg::*;
#(
	parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
	parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	logic [7:0]  mark0_q, mark1_q;
	logic [15:0] timeout_q;
	logic [5:0]  limit_q;
	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [2:0]  res_code;
	logic        res_frame;
	logic        res_last;
	logic [7:0]  ver, ftype, fflags, pbyte;
	logic [15:0] seq;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark0_q   <= 8'd170;
			mark1_q   <= 8'd85;
			timeout_q <= 16'd100;
			limit_q   <= 6'd32;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MARK0:   mark0_q   <= cfg_data[7:0];
				REG_MARK1:   mark1_q   <= cfg_data[7:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_LIMIT:   limit_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	sfp_ctrl #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_op     (in_data.operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_code  (res_code),
		.out_frame (res_frame),
		.out_last  (res_last),
		.cmd       (cmd),
		.stat      (stat)
	);

	sfp_datapath #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rx_byte     (in_data.rx_byte),
		.now_ms      (in_data.now_ms),
		.cfg_mark0   (mark0_q),
		.cfg_mark1   (mark1_q),
		.cfg_timeout (timeout_q),
		.cfg_limit   (limit_q),
		.stat        (stat),
		.version     (ver),
		.frame_type  (ftype),
		.frame_flags (fflags),
		.sequence_res(seq),
		.payload_byte(pbyte)
	);

	// results
	always_comb begin
		out_data             = '0;
		out_data.result_code = res_code;
		out_data.last        = res_last;
		if (res_frame) begin
			out_data.version      = ver;
			out_data.frame_type   = ftype;
			out_data.frame_flags  = fflags;
			out_data.sequence_res = seq;
			out_data.pay_len      = stat.len;
			out_data.payload_byte = pbyte;
		end
	end

endmodule
